### hw/rtl/periodic_timer_table_macros.svh
// Assertion macros used by the periodic timer table top module.
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ptt_pkg.sv
// Types and constants of the periodic timer table.
package ptt_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int MAX_FIRES   = 16;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int FIRE_W      = 5;
   localparam int DL_W        = 49;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_KILL  = 2'd2,
      OP_QUERY = 2'd3
   } ptt_op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_ARG = 2'd1,
      ST_FULL    = 2'd2
   } ptt_status_type;

   typedef enum logic {
      KIND_FIRE = 1'b0,
      KIND_DONE = 1'b1
   } ptt_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SET_WR,
      S_TICK_START,
      S_MARK,
      S_FIND,
      S_FIND_END,
      S_FIRE,
      S_DONE
   } ptt_state_type;

   typedef struct packed {
      logic capture;
      logic idx_clr;
      logic idx_inc;
      logic idx_load_free;
      logic idx_load_best;
      logic scan;
      logic set_write;
      logic tick_start;
      logic mark;
      logic find_clr;
      logic find;
      logic fire;
      logic emit_done;
   } ptt_cmd_type;

   typedef struct packed {
      ptt_op_type op;
      logic       bad_arg;
      logic       last_idx;
      logic       best_found;
      logic       fire_cap;
      logic       out_free;
   } ptt_sts_type;

endpackage

### hw/rtl/ptt_intf.sv
// Request and response channel interfaces of the periodic timer table.
interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] timer_id;
   logic [31:0] period;
   logic        fire_now;
   logic [47:0] current_time;

   modport source (output valid, opcode, timer_id, period, fire_now, current_time,
                   input ready);
   modport sink (input valid, opcode, timer_id, period, fire_now, current_time,
                 output ready);
endinterface

interface ptt_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] fired_id;
   logic [1:0]  status;
   logic        found;
   logic [4:0]  fire_count;
   logic        last;

   modport source (output valid, result_kind, fired_id, status, found, fire_count, last,
                   input ready);
   modport sink (input valid, result_kind, fired_id, status, found, fire_count, last,
                 output ready);
endinterface

### hw/rtl/ptt_datapath.sv
// Slot storage, scan registers and response register of the timer table.
module ptt_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ptt_pkg::ptt_cmd_type cmd,
   output ptt_pkg::ptt_sts_type sts,
   input  logic [1:0]          req_opcode,
   input  logic [15:0]         req_timer_id,
   input  logic [31:0]         req_period,
   input  logic                req_fire_now,
   input  logic [47:0]         req_current_time,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_result_kind,
   output logic [15:0]         rsp_fired_id,
   output logic [1:0]          rsp_status,
   output logic                rsp_found,
   output logic [4:0]          rsp_fire_count,
   output logic                rsp_last
);
   localparam int N = ptt_pkg::TIMER_SLOTS;
   localparam int SW = ptt_pkg::SLOT_W;
   localparam int DW = ptt_pkg::DL_W;
   localparam int FW = ptt_pkg::FIRE_W;

   ptt_pkg::ptt_op_type op_ff;
   logic [15:0]  id_ff;
   logic [31:0]  per_ff;
   logic         fnow_ff;
   logic [47:0]  now_ff;

   logic [N-1:0] valid_ff;
   logic [N-1:0] pend_ff;
   logic [15:0]  sid_ff  [N];
   logic [31:0]  sper_ff [N];
   logic [DW-1:0] sdl_ff [N];
   logic [31:0]  sseq_ff [N];
   logic [31:0]  seq_ff;

   logic [SW-1:0] idx_ff;
   logic          free_found_ff;
   logic [SW-1:0] free_idx_ff;
   logic          hit_ff;
   logic          best_found_ff;
   logic [SW-1:0] best_idx_ff;
   logic [DW-1:0] best_dl_ff;
   logic [31:0]   best_seq_ff;
   logic [FW-1:0] fired_ff;

   logic          rsp_valid_ff;
   logic          kind_ff;
   logic [15:0]   out_id_ff;
   logic [1:0]    out_status_ff;
   logic          out_found_ff;
   logic [FW-1:0] out_cnt_ff;
   logic          out_last_ff;

   logic          match;
   logic          scan_free;
   logic          better;
   logic          do_set;
   logic          out_free;
   logic [DW-1:0] now_ext;
   logic [DW-1:0] set_dl_in;
   logic [1:0]    done_status;

   assign now_ext  = {1'b0, now_ff};
   assign match    = valid_ff[idx_ff] && (sid_ff[idx_ff] == id_ff);
   // The slot under the scan is the first one that is free once a same-id timer is removed.
   assign scan_free = !free_found_ff && (!valid_ff[idx_ff] || match);
   assign better   = !best_found_ff || (sdl_ff[idx_ff] < best_dl_ff) ||
                     ((sdl_ff[idx_ff] == best_dl_ff) && (sseq_ff[idx_ff] < best_seq_ff));
   assign do_set   = cmd.set_write && free_found_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign set_dl_in = fnow_ff ? now_ext : now_ext + {{(DW-32){1'b0}}, per_ff};

   always_comb begin
      if (op_ff != ptt_pkg::OP_SET) begin
         done_status = ptt_pkg::ST_OK;
      end else if (sts.bad_arg) begin
         done_status = ptt_pkg::ST_BAD_ARG;
      end else if (!free_found_ff) begin
         done_status = ptt_pkg::ST_FULL;
      end else begin
         done_status = ptt_pkg::ST_OK;
      end
   end

   assign sts.op         = op_ff;
   assign sts.bad_arg    = (op_ff == ptt_pkg::OP_SET) && ((id_ff == 16'd0) || (per_ff == 32'd0));
   assign sts.last_idx   = (idx_ff == SW'(N - 1));
   assign sts.best_found = best_found_ff;
   assign sts.fire_cap   = (fired_ff == FW'(ptt_pkg::MAX_FIRES));
   assign sts.out_free   = out_free;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         seq_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan && match && (op_ff != ptt_pkg::OP_QUERY)) begin
            valid_ff[idx_ff] <= 1'b0;
         end
         if (do_set) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.tick_start || do_set || cmd.fire) begin
            seq_ff <= seq_ff + 32'd1;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_load_free) begin
            // The last slot of the scan may itself be the free one.
            idx_ff <= (cmd.scan && scan_free) ? idx_ff : free_idx_ff;
         end else if (cmd.idx_load_best) begin
            idx_ff <= best_idx_ff;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + SW'(1);
         end
         if (cmd.fire || cmd.emit_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= ptt_pkg::ptt_op_type'(req_opcode);
         id_ff         <= req_timer_id;
         per_ff        <= req_period;
         fnow_ff       <= req_fire_now;
         now_ff        <= req_current_time;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
      end
      if (cmd.scan) begin
         if (match) begin
            hit_ff <= 1'b1;
         end
         if (scan_free) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
      end
      if (do_set) begin
         sid_ff[idx_ff]  <= id_ff;
         sper_ff[idx_ff] <= per_ff;
         sdl_ff[idx_ff]  <= set_dl_in;
         sseq_ff[idx_ff] <= seq_ff + 32'd1;
      end
      if (cmd.tick_start) begin
         fired_ff <= '0;
      end
      if (cmd.mark) begin
         pend_ff[idx_ff] <= valid_ff[idx_ff] && (sdl_ff[idx_ff] <= now_ext);
      end
      if (cmd.find_clr) begin
         best_found_ff <= 1'b0;
      end
      if (cmd.find && pend_ff[idx_ff] && better) begin
         best_found_ff <= 1'b1;
         best_idx_ff   <= idx_ff;
         best_dl_ff    <= sdl_ff[idx_ff];
         best_seq_ff   <= sseq_ff[idx_ff];
      end
      if (cmd.fire) begin
         pend_ff[idx_ff] <= 1'b0;
         sdl_ff[idx_ff]  <= sdl_ff[idx_ff] + {{(DW-32){1'b0}}, sper_ff[idx_ff]};
         sseq_ff[idx_ff] <= seq_ff + 32'd1;
         fired_ff        <= fired_ff + FW'(1);
         kind_ff         <= ptt_pkg::KIND_FIRE;
         out_id_ff       <= sid_ff[idx_ff];
         out_status_ff   <= ptt_pkg::ST_OK;
         out_found_ff    <= 1'b0;
         out_cnt_ff      <= '0;
         out_last_ff     <= 1'b0;
      end
      if (cmd.emit_done) begin
         kind_ff       <= ptt_pkg::KIND_DONE;
         out_id_ff     <= (op_ff == ptt_pkg::OP_TICK) ? 16'd0 : id_ff;
         out_status_ff <= done_status;
         out_found_ff  <= (op_ff == ptt_pkg::OP_QUERY) && hit_ff;
         out_cnt_ff    <= (op_ff == ptt_pkg::OP_TICK) ? fired_ff : '0;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_fired_id    = out_id_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_fire_count  = out_cnt_ff;
   assign rsp_last        = out_last_ff;
endmodule

### hw/rtl/ptt_ctrl.sv
// Sequencer state machine of the periodic timer table.
module ptt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ptt_pkg::ptt_sts_type sts,
   output ptt_pkg::ptt_cmd_type cmd
);
   ptt_pkg::ptt_state_type state_ff;
   ptt_pkg::ptt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::S_IDLE: begin
            if (req_valid) state_in = ptt_pkg::S_DECODE;
         end
         ptt_pkg::S_DECODE: begin
            if (sts.op == ptt_pkg::OP_TICK) begin
               state_in = ptt_pkg::S_TICK_START;
            end else if (sts.bad_arg) begin
               state_in = ptt_pkg::S_DONE;
            end else begin
               state_in = ptt_pkg::S_SCAN;
            end
         end
         ptt_pkg::S_SCAN: begin
            if (sts.last_idx) begin
               state_in = (sts.op == ptt_pkg::OP_SET) ? ptt_pkg::S_SET_WR : ptt_pkg::S_DONE;
            end
         end
         ptt_pkg::S_SET_WR:     state_in = ptt_pkg::S_DONE;
         ptt_pkg::S_TICK_START: state_in = ptt_pkg::S_MARK;
         ptt_pkg::S_MARK: begin
            if (sts.last_idx) state_in = ptt_pkg::S_FIND;
         end
         ptt_pkg::S_FIND: begin
            if (sts.last_idx) state_in = ptt_pkg::S_FIND_END;
         end
         ptt_pkg::S_FIND_END: begin
            state_in = (sts.best_found && !sts.fire_cap) ? ptt_pkg::S_FIRE : ptt_pkg::S_DONE;
         end
         ptt_pkg::S_FIRE: begin
            if (sts.out_free) state_in = ptt_pkg::S_FIND;
         end
         ptt_pkg::S_DONE: begin
            if (sts.out_free) state_in = ptt_pkg::S_IDLE;
         end
         default: state_in = ptt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ptt_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            cmd.idx_clr = req_valid;
         end
         ptt_pkg::S_DECODE: ;
         ptt_pkg::S_SCAN: begin
            cmd.scan          = 1'b1;
            cmd.idx_inc       = 1'b1;
            cmd.idx_load_free = sts.last_idx;
         end
         ptt_pkg::S_SET_WR:     cmd.set_write = 1'b1;
         ptt_pkg::S_TICK_START: cmd.tick_start = 1'b1;
         ptt_pkg::S_MARK: begin
            cmd.mark     = 1'b1;
            cmd.idx_inc  = !sts.last_idx;
            cmd.idx_clr  = sts.last_idx;
            cmd.find_clr = sts.last_idx;
         end
         ptt_pkg::S_FIND: begin
            cmd.find    = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ptt_pkg::S_FIND_END: cmd.idx_load_best = 1'b1;
         ptt_pkg::S_FIRE: begin
            cmd.fire     = sts.out_free;
            cmd.idx_clr  = sts.out_free;
            cmd.find_clr = sts.out_free;
         end
         ptt_pkg::S_DONE: cmd.emit_done = sts.out_free;
         default: ;
      endcase
   end
endmodule

### hw/rtl/periodic_timer_table.sv
// A slot walk visits one of the sixteen slots per cycle. Kill, query and a well-formed set
// make one walk (a set then writes its slot); a set with a bad argument makes none. A tick
// makes a marking pass, then search passes, each followed by firing the timer found,
// until none is due or 16 have fired. Fire and completion steps stall while rsp is held.
// One item at a time; the next can be accepted in the cycle the completion word first shows.
// Synchronous active-high reset clears valid bits, sequence counter, index, rsp valid, state.
module periodic_timer_table (
   input logic       clock,
   input logic       reset,
   ptt_req_if.sink   req,
   ptt_rsp_if.source rsp
);
`include "periodic_timer_table_macros.svh"

   // Command and status between the sequencer and the datapath.
   ptt_pkg::ptt_cmd_type cmd;
   ptt_pkg::ptt_sts_type sts;

   // Shape checks on the response word.
   logic fire_word_ok;
   logic count_in_cap;

   // The sequencer walks the slot table one entry per cycle: one pass for
   // kill, query or a well-formed set, and for a tick one pass to mark due
   // timers followed by one search pass per fired timer and a last one.
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the slots, the scan registers and the response word
   // register, which keeps each result until the sink takes it.
   ptt_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req.opcode),
      .req_timer_id     (req.timer_id),
      .req_period       (req.period),
      .req_fire_now     (req.fire_now),
      .req_current_time (req.current_time),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_result_kind  (rsp.result_kind),
      .rsp_fired_id     (rsp.fired_id),
      .rsp_status       (rsp.status),
      .rsp_found        (rsp.found),
      .rsp_fire_count   (rsp.fire_count),
      .rsp_last         (rsp.last)
   );

   assign fire_word_ok = (rsp.result_kind == ptt_pkg::KIND_FIRE) &&
                         (rsp.status == ptt_pkg::ST_OK);
   assign count_in_cap = (rsp.fire_count <= 5'(ptt_pkg::MAX_FIRES));

   // Only the completion word closes an item, and fire words always carry status OK.
   `PTT_ASSERT_IMP(a_fire_not_last, rsp.valid && !rsp.last, fire_word_ok, "fire word malformed")
   // The block takes no new word right after accepting one.
   `PTT_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted twice")
   // A tick never reports more fires than the cap.
   `PTT_ASSERT_IMP(a_fire_cap, rsp.valid && rsp.last, count_in_cap, "fire count beyond cap")
endmodule
